>>> hdl/udphg_pkg.sv
// Shared types and constants for the UDP/IPv4 frame header generator.
// Holds the port payload structs, the queue command and the protocol constants.
// No dependencies.
package udphg_pkg;

    // Input operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam int          CFG_INDEX_W     = 3;
    localparam int          CFG_DATA_W      = 48;
    localparam logic [2:0]  REG_DEST_MAC    = 3'd0;
    localparam logic [2:0]  REG_SOURCE_MAC  = 3'd1;
    localparam logic [2:0]  REG_SOURCE_IP   = 3'd2;
    localparam logic [2:0]  REG_DEST_IP     = 3'd3;
    localparam logic [2:0]  REG_SOURCE_PORT = 3'd4;
    localparam logic [2:0]  REG_DEST_PORT   = 3'd5;

    // Header layout
    localparam int          HDR_BYTES      = 42;
    localparam int          HDR_IDX_W      = 6;
    localparam logic [5:0]  HDR_LAST_IDX   = 6'(HDR_BYTES - 1);
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TOS         = 8'h00;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
    localparam logic [15:0] IP_HDR_LEN     = 16'd28;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;

    // Command queue depth
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic        op;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       last;
        logic       run_end;
    } out_item_t;

    // One queued job for the back end: a header run or one payload byte
    typedef struct packed {
        logic        kind;
        logic [15:0] len;
        logic [7:0]  data_byte;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } cfg_t;

endpackage

>>> hdl/udp_ipv4_frame_header_generator_top.sv
// Top level of the UDP/IPv4 frame header generator: configuration registers,
// front end, command queue and back end. Depends on udphg_pkg and submodules.
//
// A start transaction produces 42 header bytes, which the back-end byte
// sequencer drives one byte per cycle into the output register while the
// output is not stalled; a payload transaction produces one byte, so payload
// streams at one byte per cycle unless the output stalls. The front end takes
// one input transaction per cycle while the four-entry command queue has room,
// so input is taken during a header run until the queue fills. An accepted
// input is registered in the command queue, then in the output register. The
// IPv4 checksum is registered as a raw sum when the start command leaves the
// queue, then folded into a checksum register, ready before its bytes go out.
module udp_ipv4_frame_header_generator_top #(
    parameter int MAX_FRAME_BYTES = 1514
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  udphg_pkg::in_item_t                    in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output udphg_pkg::out_item_t                   out_data,
    input  logic                                   cfg_we,
    input  logic [udphg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [udphg_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import udphg_pkg::*;

    cfg_t cfg_reg;
    logic fifo_full;
    logic fifo_empty;
    logic push;
    logic pop;
    cmd_t push_data;
    cmd_t pop_data;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEST_MAC:    cfg_reg.dest_mac    <= cfg_data;
                REG_SOURCE_MAC:  cfg_reg.source_mac  <= cfg_data;
                REG_SOURCE_IP:   cfg_reg.source_ip   <= cfg_data[31:0];
                REG_DEST_IP:     cfg_reg.dest_ip     <= cfg_data[31:0];
                REG_SOURCE_PORT: cfg_reg.source_port <= cfg_data[15:0];
                REG_DEST_PORT:   cfg_reg.dest_port   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    udphg_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    udphg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    udphg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_data  (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> hdl/udphg_front.sv
// Front end: accepts input transactions, clamps the length, tracks the
// remaining payload count and queues header or payload commands.
// Depends on udphg_pkg.
module udphg_front #(
    parameter int MAX_FRAME_BYTES = 1514
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  udphg_pkg::in_item_t in_data,
    input  logic                fifo_full,
    output logic                push,
    output udphg_pkg::cmd_t     push_data
);
    import udphg_pkg::*;

    localparam int          LIMIT     = MAX_FRAME_BYTES - HDR_BYTES;
    localparam int          CNT_W     = $clog2(LIMIT + 1);
    localparam logic [15:0] LIMIT_LEN = 16'(LIMIT);

    logic [CNT_W-1:0] remaining_reg;
    logic [CNT_W-1:0] remaining_next;
    logic             accept;
    logic [15:0]      clamped_len;

    // The queue having room is the only condition for taking a transaction.
    assign in_stall    = fifo_full;
    assign accept      = in_valid && !fifo_full;
    assign clamped_len = (in_data.payload_length > LIMIT_LEN) ? LIMIT_LEN
                                                              : in_data.payload_length;

    // Classify the transaction and update the payload count.
    always_comb
    begin
        remaining_next      = remaining_reg;
        push                = 1'b0;
        push_data.kind      = in_data.op;
        push_data.len       = clamped_len;
        push_data.data_byte = in_data.data_byte;
        push_data.last      = 1'b0;
        if (accept)
        begin
            if (in_data.op == OP_START)
            begin
                remaining_next = clamped_len[CNT_W-1:0];
                push           = 1'b1;
            end
            else if (remaining_reg != '0)
            begin
                remaining_next = remaining_reg - CNT_W'(1);
                push           = 1'b1;
                push_data.last = (remaining_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
        end
        else
        begin
            remaining_reg <= remaining_next;
        end
    end

endmodule

>>> hdl/udphg_fifo.sv
// Short command queue between the front end and the back end.
// Register-based, one push and one pop per cycle. Depends on udphg_pkg.
module udphg_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  udphg_pkg::cmd_t push_data,
    input  logic            pop,
    output udphg_pkg::cmd_t pop_data,
    output logic            full,
    output logic            empty
);
    import udphg_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/udphg_back.sv
// Back end: pops commands, sequences the 42 header bytes, computes the IPv4
// header checksum and drives the output register. Depends on udphg_pkg.
module udphg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  udphg_pkg::cfg_t      cfg,
    input  logic                 fifo_empty,
    input  udphg_pkg::cmd_t      fifo_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output udphg_pkg::out_item_t out_data
);
    import udphg_pkg::*;

    logic                 hdr_active_reg;
    logic                 hdr_active_next;
    logic [HDR_IDX_W-1:0] cnt_reg;
    logic [HDR_IDX_W-1:0] cnt_next;
    logic [15:0]          len_reg;
    logic [15:0]          len_next;
    logic [18:0]          sum_reg;
    logic [18:0]          sum_next;
    logic [15:0]          csum_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;
    out_item_t            out_data_next;

    logic                 advance;
    logic [15:0]          pop_ip_len;
    logic [15:0]          ip_len;
    logic [15:0]          udp_len;
    logic [16:0]          fold1;
    logic [15:0]          fold2;
    logic [HDR_BYTES*8-1:0] hdr_vec;
    logic [7:0]           hdr_byte;

    assign advance   = !out_valid_reg || !out_stall;
    assign pop       = advance && !hdr_active_reg && !fifo_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checksum: raw sum is taken when the start command is popped, then
    // folded twice with end-around carry into a register well before use.
    assign pop_ip_len = fifo_data.len + IP_HDR_LEN;
    assign sum_next   = 19'({IP_VER_IHL, IP_TOS}) + 19'(pop_ip_len)
                      + 19'({IP_TTL, IP_PROTO_UDP})
                      + 19'(cfg.source_ip[31:16]) + 19'(cfg.source_ip[15:0])
                      + 19'(cfg.dest_ip[31:16]) + 19'(cfg.dest_ip[15:0]);
    assign fold1      = 17'(sum_reg[15:0]) + 17'(sum_reg[18:16]);
    assign fold2      = fold1[15:0] + 16'(fold1[16]);

    // Header image in network order, first byte in the top bits.
    assign ip_len  = len_reg + IP_HDR_LEN;
    assign udp_len = len_reg + UDP_HDR_LEN;
    assign hdr_vec = {cfg.dest_mac, cfg.source_mac, ETHERTYPE_IPV4,
                      IP_VER_IHL, IP_TOS, ip_len, 32'h0000_0000,
                      IP_TTL, IP_PROTO_UDP, csum_reg,
                      cfg.source_ip, cfg.dest_ip,
                      cfg.source_port, cfg.dest_port, udp_len, 16'h0000};
    assign hdr_byte = hdr_vec[(HDR_BYTES - 1 - int'(cnt_reg)) * 8 +: 8];

    // Sequencer and output register load
    always_comb
    begin
        hdr_active_next = hdr_active_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (advance)
        begin
            if (hdr_active_reg)
            begin
                out_valid_next          = 1'b1;
                out_data_next.out_byte  = hdr_byte;
                out_data_next.is_header = 1'b1;
                out_data_next.run_end   = (cnt_reg == HDR_LAST_IDX);
                out_data_next.last      = (cnt_reg == HDR_LAST_IDX) && (len_reg == '0);
                cnt_next                = cnt_reg + HDR_IDX_W'(1);
                if (cnt_reg == HDR_LAST_IDX)
                begin
                    hdr_active_next = 1'b0;
                end
            end
            else if (!fifo_empty)
            begin
                out_valid_next = 1'b1;
                if (fifo_data.kind == OP_START)
                begin
                    // First header byte goes out as the command is popped.
                    out_data_next.out_byte  = cfg.dest_mac[47:40];
                    out_data_next.is_header = 1'b1;
                    out_data_next.run_end   = 1'b0;
                    out_data_next.last      = 1'b0;
                    hdr_active_next         = 1'b1;
                    cnt_next                = HDR_IDX_W'(1);
                    len_next                = fifo_data.len;
                end
                else
                begin
                    out_data_next.out_byte  = fifo_data.data_byte;
                    out_data_next.is_header = 1'b0;
                    out_data_next.run_end   = 1'b1;
                    out_data_next.last      = fifo_data.last;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        out_data_reg <= out_data_next;
        csum_reg     <= ~fold2;
        if (pop && (fifo_data.kind == OP_START))
        begin
            sum_reg <= sum_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_active_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hdr_active_reg <= hdr_active_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

>>> hdl/udphg_checker.sv
// Port-level checker for the frame header generator and its bind statement.
// Depends on udphg_pkg and udp_ipv4_frame_header_generator_top.
module udphg_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input udphg_pkg::out_item_t out_data
);
    import udphg_pkg::*;

    // A stalled output transaction holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

    // The final byte of a frame always closes the run of its input item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.run_end)
    else $error("frame end without run end");

    // A payload byte is a run of its own.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_header |-> out_data.run_end)
    else $error("payload byte without run end");

endmodule

bind udp_ipv4_frame_header_generator_top udphg_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
